FILE: rtl/core/rre_pkg.sv
package rre_pkg;

    localparam int DEF_FRAC_BITS   = 8;
    localparam int DEF_SAMPLE_BITS = 36;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_RTO   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RTO   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_SRTT = 2'd2;

    localparam logic [31:0] MIN_RTO_RESET   = 32'd200000;
    localparam logic [31:0] MAX_RTO_RESET   = 32'd60000000;
    localparam logic [31:0] INIT_SRTT_RESET = 32'd1500000;

    localparam int TIME_BITS     = 64;
    localparam int OUT_SRTT_BITS = 36;
    localparam int OUT_RTO_BITS  = 32;
    localparam logic [63:0] OUT_SRTT_MAX = (64'd1 << OUT_SRTT_BITS) - 64'd1;

    typedef struct packed {
        logic [31:0] min_rto_us;
        logic [31:0] max_rto_us;
        logic [31:0] initial_srtt_us;
    } cfg_t;

endpackage

FILE: rtl/core/rtt_rto_estimator.sv
// A word accepted on the input passes the input register, time difference,
// sample, filter state and result register before it shows on m_valid.
// Throughput: one word per cycle unless m_ready stalls the output.
// Reset: synchronous active-low aresetn clears the pipeline, the smoothed state
// and the no-sample flag, and loads the default min/max RTO and initial SRTT.
module rtt_rto_estimator
    import rre_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [TIME_BITS-1:0]      s_sent_time_us,
    input  logic [TIME_BITS-1:0]      s_received_time_us,
    input  logic [TIME_BITS-1:0]      s_peer_delay_us,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OUT_SRTT_BITS-1:0]  m_smoothed_rtt_us,
    output logic [OUT_RTO_BITS-1:0]   m_timeout_us,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int W = SAMPLE_BITS + FRAC_BITS;

    cfg_t         cfg;
    logic         smp_valid, smp_ready;
    logic [W-1:0] smp_fx;
    logic         flt_valid, flt_ready;
    logic [W-1:0] flt_srtt, flt_dev;

    rre_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rre_sample #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sample (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .sent_time_us     (s_sent_time_us),
        .received_time_us (s_received_time_us),
        .peer_delay_us    (s_peer_delay_us),
        .o_valid          (smp_valid),
        .o_ready          (smp_ready),
        .o_sample_fx      (smp_fx)
    );

    rre_filter #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .i_valid     (smp_valid),
        .i_ready     (smp_ready),
        .i_sample_fx (smp_fx),
        .o_valid     (flt_valid),
        .o_ready     (flt_ready),
        .o_srtt      (flt_srtt),
        .o_dev       (flt_dev)
    );

    rre_timeout #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_timeout (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .i_valid           (flt_valid),
        .i_ready           (flt_ready),
        .i_srtt            (flt_srtt),
        .i_dev             (flt_dev),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_smoothed_rtt_us (m_smoothed_rtt_us),
        .m_timeout_us      (m_timeout_us)
    );

endmodule

FILE: rtl/core/rre_cfg.sv
module rre_cfg
    import rre_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_rto_us      <= MIN_RTO_RESET;
            cfg_reg.max_rto_us      <= MAX_RTO_RESET;
            cfg_reg.initial_srtt_us <= INIT_SRTT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_RTO:   cfg_reg.min_rto_us      <= cfg_data;
                CFG_MAX_RTO:   cfg_reg.max_rto_us      <= cfg_data;
                CFG_INIT_SRTT: cfg_reg.initial_srtt_us <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/core/rre_sample.sv
module rre_sample
    import rre_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int W = SAMPLE_BITS + FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_BITS-1:0] sent_time_us,
    input  logic [TIME_BITS-1:0] received_time_us,
    input  logic [TIME_BITS-1:0] peer_delay_us,
    output logic                 o_valid,
    input  logic                 o_ready,
    output logic [W-1:0]         o_sample_fx
);

    localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

    // stage 0: input word
    logic                 v0_reg;
    logic [TIME_BITS-1:0] sent_reg, rcvd_reg, delay0_reg;
    // stage 1: receive minus send
    logic                 v1_reg;
    logic [TIME_BITS-1:0] diff_reg, delay1_reg;
    logic                 neg1_reg;
    // stage 2: saturated sample in fixed point
    logic                 v2_reg;
    logic [W-1:0]         sfx_reg;

    logic rdy0, rdy1, rdy2;
    logic [TIME_BITS:0]   diff_next, net_next;
    logic [TIME_BITS-1:0] sample64;
    logic [SAMPLE_BITS-1:0] sample;

    assign rdy2    = !v2_reg || o_ready;
    assign rdy1    = !v1_reg || rdy2;
    assign rdy0    = !v0_reg || rdy1;
    assign s_ready = rdy0;
    assign o_valid     = v2_reg;
    assign o_sample_fx = sfx_reg;

    always_comb begin
        diff_next = {1'b0, rcvd_reg} - {1'b0, sent_reg};
        net_next  = {1'b0, diff_reg} - {1'b0, delay1_reg};
        sample64  = net_next[TIME_BITS-1:0];
        if (neg1_reg || net_next[TIME_BITS]) begin
            sample = '0;
        end else if (sample64 > SAMPLE_MAX) begin
            sample = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else begin
            sample = sample64[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_valid) begin
            sent_reg   <= sent_time_us;
            rcvd_reg   <= received_time_us;
            delay0_reg <= peer_delay_us;
        end
        if (rdy1 && v0_reg) begin
            diff_reg   <= diff_next[TIME_BITS-1:0];
            neg1_reg   <= diff_next[TIME_BITS];
            delay1_reg <= delay0_reg;
        end
        if (rdy2 && v1_reg) begin
            sfx_reg <= {sample, {FRAC_BITS{1'b0}}};
        end
    end

endmodule

FILE: rtl/core/rre_filter.sv
module rre_filter
    import rre_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int W = SAMPLE_BITS + FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         i_valid,
    output logic         i_ready,
    input  logic [W-1:0] i_sample_fx,
    output logic         o_valid,
    input  logic         o_ready,
    output logic [W-1:0] o_srtt,
    output logic [W-1:0] o_dev
);

    localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;

    logic         v_reg;
    logic         have_reg;
    logic [W-1:0] srtt_reg, dev_reg;
    logic [W-1:0] srtt_next, dev_next;

    logic [63:0]            init64;
    logic [SAMPLE_BITS-1:0] init_sat;
    logic [W-1:0]           prev_srtt, prev_dev, err;
    logic signed [W:0]      d_srtt, d_dev, sum_srtt, sum_dev;
    logic                   take;

    assign i_ready = !v_reg || o_ready;
    assign take    = i_valid && i_ready;
    assign o_valid = v_reg;
    assign o_srtt  = srtt_reg;
    assign o_dev   = dev_reg;

    always_comb begin
        init64 = {32'd0, cfg.initial_srtt_us};
        if (init64 > SAMPLE_MAX) begin
            init_sat = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else begin
            init_sat = init64[SAMPLE_BITS-1:0];
        end
        // before the first sample: configured SRTT, zero deviation
        prev_srtt = have_reg ? srtt_reg : {init_sat, {FRAC_BITS{1'b0}}};
        prev_dev  = have_reg ? dev_reg  : '0;

        // arithmetic shift of the signed error gives floor for both signs
        d_srtt    = $signed({1'b0, i_sample_fx}) - $signed({1'b0, prev_srtt});
        sum_srtt  = $signed({1'b0, prev_srtt}) + (d_srtt >>> 3);
        srtt_next = sum_srtt[W-1:0];

        err       = d_srtt[W] ? W'(-d_srtt) : d_srtt[W-1:0];
        d_dev     = $signed({1'b0, err}) - $signed({1'b0, prev_dev});
        sum_dev   = $signed({1'b0, prev_dev}) + (d_dev >>> 2);
        dev_next  = sum_dev[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= 1'b0;
            have_reg <= 1'b0;
            srtt_reg <= '0;
            dev_reg  <= '0;
        end else begin
            if (i_ready) v_reg <= i_valid;
            if (take) begin
                have_reg <= 1'b1;
                srtt_reg <= srtt_next;
                dev_reg  <= dev_next;
            end
        end
    end

    a_have_set: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> have_reg)
        else $error("have_reg not set after a sample");

    a_have_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        have_reg |=> have_reg)
        else $error("have_reg cleared outside reset");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg && !o_ready |=> $stable(srtt_reg) && $stable(dev_reg) && v_reg)
        else $error("filter state moved while result stalled");

endmodule

FILE: rtl/core/rre_timeout.sv
module rre_timeout
    import rre_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int W = SAMPLE_BITS + FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     i_valid,
    output logic                     i_ready,
    input  logic [W-1:0]             i_srtt,
    input  logic [W-1:0]             i_dev,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OUT_SRTT_BITS-1:0] m_smoothed_rtt_us,
    output logic [OUT_RTO_BITS-1:0]  m_timeout_us
);

    logic                     m_valid_reg;
    logic [OUT_SRTT_BITS-1:0] srtt_out_reg;
    logic [OUT_RTO_BITS-1:0]  rto_out_reg;

    logic [W+2:0]             rto_fx;
    logic [63:0]              rto64, srtt64;
    logic [OUT_RTO_BITS-1:0]  rto_next;
    logic [OUT_SRTT_BITS-1:0] srtt_next;

    assign i_ready           = !m_valid_reg || m_ready;
    assign m_valid           = m_valid_reg;
    assign m_smoothed_rtt_us = srtt_out_reg;
    assign m_timeout_us      = rto_out_reg;

    always_comb begin
        rto_fx = {3'b000, i_srtt} + {1'b0, i_dev, 2'b00};
        rto64  = 64'(rto_fx[W+2:FRAC_BITS]);
        // min is checked first, so when min > max a value below min gives min, else max
        if (rto64 < {32'd0, cfg.min_rto_us}) begin
            rto_next = cfg.min_rto_us;
        end else if (rto64 > {32'd0, cfg.max_rto_us}) begin
            rto_next = cfg.max_rto_us;
        end else begin
            rto_next = rto64[OUT_RTO_BITS-1:0];
        end

        srtt64 = 64'(i_srtt[W-1:FRAC_BITS]);
        if (srtt64 > OUT_SRTT_MAX) begin
            srtt_next = OUT_SRTT_MAX[OUT_SRTT_BITS-1:0];
        end else begin
            srtt_next = srtt64[OUT_SRTT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (i_ready) begin
            m_valid_reg <= i_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_ready && i_valid) begin
            srtt_out_reg <= srtt_next;
            rto_out_reg  <= rto_next;
        end
    end

endmodule
